// File: src/blc_pkg.sv
// ----------------------------------------------------------------------------
// blc_pkg: shared types and constants for the bit-plane cell update core
// Grid geometry, pixel and rule widths, command codes, and the control
// struct that the sequencer sends to the neighbor counting unit.
// ----------------------------------------------------------------------------
package blc_pkg;

    // Grid geometry: the pixel store holds MAX_ROWS x MAX_COLS entries.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;

    // Size registers are 7 bits wide.
    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] MAX_ROWS_SZ = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] MAX_COLS_SZ = SIZE_W'(MAX_COLS);

    // Pixel and rule layout.
    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;
    localparam int RULE_W = 18;
    localparam int CNT_W  = 4;
    localparam int POS_W  = $clog2(RULE_W);
    localparam logic [RULE_W-1:0] RULE_RESET     = 18'h01808;
    localparam logic [POS_W-1:0]  SURVIVE_OFFSET = 5'd9;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RULE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RULE_WORD = 2'd0,
        REG_GRID_ROWS = 2'd1,
        REG_GRID_COLS = 2'd2
    } cfg_reg_t;

    // Input command codes, carried in s_tuser.
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    // Stream widths.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // Control from the sequencer to the counting unit.
    typedef struct packed {
        logic load_self;
        logic add;
    } accum_ctl_t;

endpackage

// File: src/bitplane_life_cell_update_core.sv
// ----------------------------------------------------------------------------
// bitplane_life_cell_update_core: bit-plane cellular automaton cell update
// Writes: a write transfer is stored in the cycle it is accepted and gives
// no result. An in-grid evaluate reads the cell and its eight neighbors in
// turn through the single port of the pixel store, then drains and gives its
// result once the output is free; no transfer is taken until it is done.
// Reset: control and configuration registers reset; the pixel store does not.
// ----------------------------------------------------------------------------
module bitplane_life_cell_update_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [blc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [blc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: row[5:0], col[11:6], red[19:12], green[27:20], blue[35:28],
    // zero[39:36]
    input  logic [blc_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: command[0]
    input  logic                          s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: next_red[7:0], next_green[15:8], next_blue[23:16]
    output logic [blc_pkg::M_DATA_W-1:0]   m_tdata
);
    import blc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN
    } state_t;

    typedef enum logic [3:0] {
        STEP_SELF, STEP_UL, STEP_U, STEP_UR, STEP_L,
        STEP_R, STEP_DL, STEP_D, STEP_DR
    } step_t;

    // Configuration registers.
    logic [RULE_W-1:0] rule_word_reg;
    logic [SIZE_W-1:0] grid_rows_reg;
    logic [SIZE_W-1:0] grid_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_word_reg <= RULE_RESET;
            grid_rows_reg <= MAX_ROWS_SZ;
            grid_cols_reg <= MAX_COLS_SZ;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_RULE_WORD: rule_word_reg <= cfg_wr_data;
                REG_GRID_ROWS: grid_rows_reg <= cfg_wr_data[SIZE_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_wr_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid size in use: zero counts as one, oversize as the maximum.
    logic [SIZE_W-1:0] rows_eff;
    logic [SIZE_W-1:0] cols_eff;

    always_comb begin
        if (grid_rows_reg == '0) begin
            rows_eff = SIZE_W'(1);
        end else if (grid_rows_reg > MAX_ROWS_SZ) begin
            rows_eff = MAX_ROWS_SZ;
        end else begin
            rows_eff = grid_rows_reg;
        end
        if (grid_cols_reg == '0) begin
            cols_eff = SIZE_W'(1);
        end else if (grid_cols_reg > MAX_COLS_SZ) begin
            cols_eff = MAX_COLS_SZ;
        end else begin
            cols_eff = grid_cols_reg;
        end
    end

    // Input fields.
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic [PIX_W-1:0] in_pixel;

    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_pixel = {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};

    // Bounds check and wrapped neighbor coordinates.
    logic             in_inside;
    logic [SIZE_W-1:0] rows_m1, cols_m1, row_p1, col_p1;
    logic [ROW_W-1:0] up_w, dn_w;
    logic [COL_W-1:0] lf_w, rt_w;

    always_comb begin
        in_inside = ({1'b0, in_row} < rows_eff) && ({1'b0, in_col} < cols_eff);
        rows_m1 = rows_eff - SIZE_W'(1);
        cols_m1 = cols_eff - SIZE_W'(1);
        row_p1  = {1'b0, in_row} + SIZE_W'(1);
        col_p1  = {1'b0, in_col} + SIZE_W'(1);
        up_w = (in_row == '0) ? rows_m1[ROW_W-1:0] : in_row - ROW_W'(1);
        dn_w = (row_p1 >= rows_eff) ? '0 : row_p1[ROW_W-1:0];
        lf_w = (in_col == '0) ? cols_m1[COL_W-1:0] : in_col - COL_W'(1);
        rt_w = (col_p1 >= cols_eff) ? '0 : col_p1[COL_W-1:0];
    end

    // Sequencer state.
    state_t           state_reg;
    step_t            step_reg;
    logic             rd_live_reg;
    logic             rd_self_reg;
    logic             zero_reg;
    logic [ROW_W-1:0] row_reg, up_reg, dn_reg;
    logic [COL_W-1:0] col_reg, lf_reg, rt_reg;
    logic             m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic             s_accept;
    logic [PIX_W-1:0] ram_rd_data;
    logic [PIX_W-1:0] next_color;
    logic             out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Address of the cell read at each step.
    logic [ROW_W-1:0] step_row;
    logic [COL_W-1:0] step_col;

    always_comb begin
        case (step_reg)
            STEP_SELF: begin step_row = row_reg; step_col = col_reg; end
            STEP_UL:   begin step_row = up_reg;  step_col = lf_reg;  end
            STEP_U:    begin step_row = up_reg;  step_col = col_reg; end
            STEP_UR:   begin step_row = up_reg;  step_col = rt_reg;  end
            STEP_L:    begin step_row = row_reg; step_col = lf_reg;  end
            STEP_R:    begin step_row = row_reg; step_col = rt_reg;  end
            STEP_DL:   begin step_row = dn_reg;  step_col = lf_reg;  end
            STEP_D:    begin step_row = dn_reg;  step_col = col_reg; end
            STEP_DR:   begin step_row = dn_reg;  step_col = rt_reg;  end
            default:   begin step_row = row_reg; step_col = col_reg; end
        endcase
    end

    // Pixel store port: writes come straight from an accepted transfer.
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;

    assign ram_we   = s_accept && (s_tuser == CMD_WRITE) && in_inside;
    assign ram_re   = (state_reg == S_RUN);
    assign ram_addr = (state_reg == S_IDLE) ? {in_row, in_col} : {step_row, step_col};

    blc_pixel_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .rd_en   (ram_re),
        .addr    (ram_addr),
        .wr_data (in_pixel),
        .rd_data (ram_rd_data)
    );

    // Read data is registered, so it arrives in the cycle after its address.
    accum_ctl_t accum_ctl;

    assign accum_ctl.load_self = rd_live_reg && rd_self_reg;
    assign accum_ctl.add       = rd_live_reg && !rd_self_reg;

    blc_plane_accum u_accum (
        .aclk       (aclk),
        .ctl        (accum_ctl),
        .pix_data   (ram_rd_data),
        .rule_word  (rule_word_reg),
        .next_color (next_color)
    );

    // Sequencer and registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= STEP_SELF;
            rd_live_reg  <= 1'b0;
            rd_self_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_live_reg <= ram_re;
            rd_self_reg <= (step_reg == STEP_SELF);
            // The finish step loads the next result itself.
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept && (s_tuser == CMD_EVAL)) begin
                        zero_reg <= !in_inside;
                        row_reg  <= in_row;
                        col_reg  <= in_col;
                        up_reg   <= up_w;
                        dn_reg   <= dn_w;
                        lf_reg   <= lf_w;
                        rt_reg   <= rt_w;
                        step_reg <= STEP_SELF;
                        state_reg <= in_inside ? S_RUN : S_FIN;
                    end
                end
                S_RUN: begin
                    if (step_reg == STEP_DR) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        step_reg <= step_t'(step_reg + 4'd1);
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    // Wait until the result register can take a new transfer.
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= zero_reg ? '0 :
                            {next_color[7:0], next_color[15:8], next_color[23:16]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/blc_pixel_ram.sv
// ----------------------------------------------------------------------------
// blc_pixel_ram: single-port pixel store
// One access a cycle, either a write or a read; read data is registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module blc_pixel_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic                      rd_en,
    input  logic [blc_pkg::ADDR_W-1:0] addr,
    input  logic [blc_pkg::PIX_W-1:0]  wr_data,
    output logic [blc_pkg::PIX_W-1:0]  rd_data
);
    import blc_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // Single port: a write takes the port, otherwise a read may.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end else if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/blc_plane_accum.sv
// ----------------------------------------------------------------------------
// blc_plane_accum: shared neighbor counting unit
// Holds the center cell and one 4-bit neighbor counter per bit plane. Each
// neighbor pixel read from the store is added into all 24 counters at once;
// the rule lookup turns the counts into the next-generation color.
// ----------------------------------------------------------------------------
module blc_plane_accum (
    input  logic                      aclk,
    input  blc_pkg::accum_ctl_t       ctl,
    input  logic [blc_pkg::PIX_W-1:0]  pix_data,
    input  logic [blc_pkg::RULE_W-1:0] rule_word,
    output logic [blc_pkg::PIX_W-1:0]  next_color
);
    import blc_pkg::*;

    logic [PIX_W-1:0] self_reg;
    logic [CNT_W-1:0] count_reg [PIX_W];

    // Loading the center cell also clears the counters for a new cell.
    always_ff @(posedge aclk) begin
        if (ctl.load_self) begin
            self_reg <= pix_data;
            for (int b = 0; b < PIX_W; b++) begin
                count_reg[b] <= '0;
            end
        end else if (ctl.add) begin
            for (int b = 0; b < PIX_W; b++) begin
                count_reg[b] <= count_reg[b] + CNT_W'(pix_data[b]);
            end
        end
    end

    // Per-plane rule lookup: survival bits sit above the birth bits.
    always_comb begin
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int b = 0; b < PIX_W; b++) begin
            pos = POS_W'(count_reg[b]) + (self_reg[b] ? SURVIVE_OFFSET : POS_W'(0));
            next_color[b] = rule_word[pos];
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for bitplane_life_cell_update_core
// Sends write and evaluate transfers into the cell update core under several
// rule and grid settings and flow-control mixes. An in-bench model of the
// pixel grid works out each next-generation color by counting neighbors per
// bit plane, and every result transfer is compared with it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import blc_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    // Index 3 is not a register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Rule words used by the directed tests.
    localparam logic [RULE_W-1:0] RULE_NONE      = 18'h00000;
    localparam logic [RULE_W-1:0] RULE_ALL       = 18'h3FFFF;
    localparam logic [RULE_W-1:0] RULE_SURVIVE_8 = 18'h20000;
    localparam logic [RULE_W-1:0] RULE_BIRTH_0   = 18'h00001;

    // One pixel, laid out as on m_tdata: red in the low byte.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } color_t;

    // Payload of one input transfer, first field in the low bits.
    typedef struct packed {
        logic [3:0]       pad;
        color_t           color;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cell_item_t;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    // s_tdata: row[5:0], col[11:6], red[19:12], green[27:20], blue[35:28],
    // zero[39:36]
    logic [S_DATA_W-1:0]   s_tdata      = '0;
    // s_tuser: command[0]
    logic                  s_tuser      = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    // m_tdata: next_red[7:0], next_green[15:8], next_blue[23:16]
    logic [M_DATA_W-1:0]   m_tdata;

    // Model of the grid and the configuration registers.
    color_t            cell_mem     [DEPTH];
    bit                cell_written [DEPTH];
    logic [RULE_W-1:0] rule_word_q  = RULE_RESET;
    logic [SIZE_W-1:0] grid_rows_q  = MAX_ROWS_SZ;
    logic [SIZE_W-1:0] grid_cols_q  = MAX_COLS_SZ;
    color_t            expected_colors [$];

    int mismatch_count    = 0;
    int cell_updates_seen = 0;
    int transfers_sent    = 0;
    int settings_used     = 0;
    int quiet_cycles      = 0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;

    bitplane_life_cell_update_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Size register as the core applies it: zero means one, large values clamp.
    function automatic int span(logic [SIZE_W-1:0] v, int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    function automatic int cell_addr(int r, int c);
        return r * MAX_COLS + c;
    endfunction

    // Per bit plane, count the eight wrapped neighbors and pick the birth or
    // survival half of the rule word by the cell's own bit.
    function automatic color_t next_generation(int r, int c);
        int               rows;
        int               cols;
        int               alive;
        int               idx;
        color_t           self_px;
        logic [PIX_W-1:0] next_px;
        rows    = span(grid_rows_q, MAX_ROWS);
        cols    = span(grid_cols_q, MAX_COLS);
        self_px = cell_mem[cell_addr(r, c)];
        next_px = '0;
        for (int b = 0; b < PIX_W; b++) begin
            alive = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if (dr != 0 || dc != 0) begin
                        alive += int'(cell_mem[cell_addr((r + dr + rows) % rows,
                                                         (c + dc + cols) % cols)][b]);
                    end
                end
            end
            idx        = self_px[b] ? alive + int'(SURVIVE_OFFSET) : alive;
            next_px[b] = rule_word_q[idx];
        end
        return color_t'(next_px);
    endfunction

    // Pixel content biased toward empty and full planes so that neighbor
    // counts of zero and eight come up often.
    function automatic color_t random_color();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return color_t'(PIX_W'($urandom & $urandom & $urandom));
            3: return color_t'(PIX_W'($urandom | $urandom));
            default: return color_t'(PIX_W'($urandom));
        endcase
    endfunction

    // Coordinate near an anchor most of the time, so written cells get reused.
    function automatic int pick_coord(int limit, int anchor);
        if ($urandom_range(99) < 70) return (anchor + int'($urandom_range(4))) % limit;
        return int'($urandom_range(limit - 1));
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("Mismatch: %s", msg);
    endtask

    // Register write; the model follows the same register map.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_RULE_WORD: rule_word_q = value[RULE_W-1:0];
            REG_GRID_ROWS: grid_rows_q = value[SIZE_W-1:0];
            REG_GRID_COLS: grid_cols_q = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Stop sending, wait for every result, then give the core time to finish
    // any write still in flight.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [RULE_W-1:0] rule, logic [SIZE_W-1:0] rows,
                              logic [SIZE_W-1:0] cols);
        quiesce();
        write_reg(REG_RULE_WORD, CFG_DATA_W'(rule));
        write_reg(REG_GRID_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_GRID_COLS, CFG_DATA_W'(cols));
        settings_used++;
    endtask

    // Send one input transfer and update the model once it is accepted.
    task automatic send_item(cmd_t cmd, int row, int col, color_t px);
        cell_item_t item;
        bit         in_grid;
        int         a;
        item.pad   = '0;
        item.color = px;
        item.col   = col[COL_W-1:0];
        item.row   = row[ROW_W-1:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(item);
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        transfers_sent++;
        in_grid = (row < span(grid_rows_q, MAX_ROWS)) && (col < span(grid_cols_q, MAX_COLS));
        a       = cell_addr(row, col);
        if (cmd == CMD_WRITE) begin
            if (in_grid) begin
                cell_mem[a]     = px;
                cell_written[a] = 1'b1;
            end
        end else begin
            expected_colors.push_back(in_grid ? next_generation(row, col) : color_t'('0));
        end
    endtask

    // Evaluate an in-grid cell, first writing any cell of its neighborhood
    // that has never been stored.
    task automatic eval_cell(int row, int col);
        int rows;
        int cols;
        int wr;
        int wc;
        rows = span(grid_rows_q, MAX_ROWS);
        cols = span(grid_cols_q, MAX_COLS);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                wr = (row + dr + rows) % rows;
                wc = (col + dc + cols) % cols;
                if (!cell_written[cell_addr(wr, wc)]) begin
                    send_item(CMD_WRITE, wr, wc, random_color());
                end
            end
        end
        send_item(CMD_EVAL, row, col, random_color());
    endtask

    // One- and four-cell grids, where wrapped neighbors repeat or are the cell
    // itself; size zero must act as one.
    task automatic test_tiny_grids();
        set_config(RULE_SURVIVE_8, 7'd0, 7'd1);
        send_item(CMD_WRITE, 0, 0, color_t'(24'hC35A0F));
        send_item(CMD_EVAL, 0, 0, '0);
        set_config(RULE_BIRTH_0, 7'd1, 7'd0);
        send_item(CMD_EVAL, 0, 0, '1);
        set_config(RULE_RESET, 7'd2, 7'd2);
        eval_cell(1, 1);
        eval_cell(0, 0);
    endtask

    // A write to the unused register index must leave the rule and size alone.
    task automatic test_unknown_register();
        quiesce();
        write_reg(REG_UNUSED, '1);
        send_item(CMD_EVAL, 1, 0, random_color());
    endtask

    // Coordinates at or past the grid size: writes dropped, evaluates zero
    // even under a rule that sets every bit.
    task automatic test_out_of_range();
        set_config(RULE_ALL, 7'd2, 7'd2);
        send_item(CMD_WRITE, 2, 0, '1);
        send_item(CMD_WRITE, 0, 63, '1);
        send_item(CMD_WRITE, 63, 63, '1);
        send_item(CMD_EVAL, 2, 0, '1);
        send_item(CMD_EVAL, 0, 63, '1);
        send_item(CMD_EVAL, 63, 63, '1);
        send_item(CMD_EVAL, 1, 0, '0);
    endtask

    // Full-size grid with the row register above its maximum; the far corner
    // wraps to row zero and column zero.
    task automatic test_full_grid_wrap();
        set_config(RULE_RESET, 7'd127, 7'd64);
        send_item(CMD_WRITE, 63, 63, '1);
        send_item(CMD_WRITE, 0, 0, '0);
        eval_cell(63, 63);
    endtask

    // Random traffic under one setting: mostly evaluates with defined
    // neighborhoods, mixed with overwrites and out-of-range transfers.
    task automatic test_random_traffic(int send_pct, int stall_pct, logic [RULE_W-1:0] rule,
                                       logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols,
                                       int n_items);
        int first;
        int rows_eff;
        int cols_eff;
        int anchor_r;
        int anchor_c;
        int r;
        int c;
        int pick;
        set_config(rule, rows, cols);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        rows_eff = span(grid_rows_q, MAX_ROWS);
        cols_eff = span(grid_cols_q, MAX_COLS);
        anchor_r = int'($urandom_range(rows_eff - 1));
        anchor_c = int'($urandom_range(cols_eff - 1));
        first    = transfers_sent;
        while (transfers_sent - first < n_items) begin
            pick = int'($urandom_range(99));
            if (pick < 30) begin
                if ($urandom_range(9) == 0) begin
                    r = int'($urandom_range(MAX_ROWS - 1));
                    c = int'($urandom_range(MAX_COLS - 1));
                end else begin
                    r = pick_coord(rows_eff, anchor_r);
                    c = pick_coord(cols_eff, anchor_c);
                end
                send_item(CMD_WRITE, r, c, random_color());
            end else if (pick < 40) begin
                r = int'($urandom_range(MAX_ROWS - 1));
                c = int'($urandom_range(MAX_COLS - 1));
                if (r < rows_eff && c < cols_eff) eval_cell(r, c);
                else send_item(CMD_EVAL, r, c, random_color());
            end else begin
                eval_cell(pick_coord(rows_eff, anchor_r), pick_coord(cols_eff, anchor_c));
            end
        end
    endtask

    // Result side: random back-pressure, comparison with the oldest expected
    // color, and a watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        color_t got;
        color_t want;
        string  chan_name [3];
        chan_name = '{"next_red", "next_green", "next_blue"};
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = color_t'(m_tdata);
                if (expected_colors.size() == 0) begin
                    flag_mismatch($sformatf("result %06h with nothing expected", got));
                end else begin
                    want = expected_colors.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got[CHAN_W*i +: CHAN_W] !== want[CHAN_W*i +: CHAN_W]) begin
                            flag_mismatch($sformatf("%s of cell update %0d: expected %02h, got %02h",
                                          chan_name[i], cell_updates_seen,
                                          want[CHAN_W*i +: CHAN_W], got[CHAN_W*i +: CHAN_W]));
                        end
                    end
                end
                cell_updates_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_colors.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_tiny_grids();
        test_unknown_register();
        test_out_of_range();
        test_full_grid_wrap();

        test_random_traffic(0, 0, RULE_W'($urandom), 7'd64, 7'd64, 225);
        test_random_traffic(0, 0, RULE_NONE, 7'd5, 7'd7, 225);
        test_random_traffic(49, 0, RULE_ALL, 7'd2, 7'd64, 225);
        test_random_traffic(49, 0, RULE_W'($urandom), 7'd64, 7'd1, 225);
        test_random_traffic(0, 49, RULE_W'($urandom), 7'd0, 7'd3, 225);
        test_random_traffic(0, 49, RULE_RESET, 7'd9, 7'd100, 225);
        test_random_traffic(26, 26, RULE_W'($urandom), SIZE_W'($urandom_range(64, 1)),
                            SIZE_W'($urandom_range(64, 1)), 225);
        test_random_traffic(26, 26, RULE_W'($urandom), 7'd3, 7'd4, 225);

        quiesce();
        $display("Sent %0d transfers and checked %0d cell updates over %0d rule and grid",
                 transfers_sent, cell_updates_seen, settings_used);
        $display("settings, with idle sender and stalled receiver mixed in four ways.");
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: bitplane_life_cell_update_core.f
src/blc_pkg.sv
src/blc_pixel_ram.sv
src/blc_plane_accum.sv
src/bitplane_life_cell_update_core.sv
tb/testbench.sv
